>>> rtl/double_buffered_event_stack_unit_macros.svh
// assertion macros for the double-buffered event stack unit
// used by the modules in rtl/ that carry concurrent checks; no other dependencies
`ifndef DOUBLE_BUFFERED_EVENT_STACK_UNIT_MACROS_SVH
`define DOUBLE_BUFFERED_EVENT_STACK_UNIT_MACROS_SVH

// condition holds at every clock edge out of reset
`define DBES_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define DBES_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define DBES_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/dbes_pkg.sv
// shared types, constants and helpers for the double-buffered event stack unit
// no dependencies; used by double_buffered_event_stack_unit and tb_top
`timescale 1ns / 1ps

package dbes_pkg;

  // entries per list, two lists share one memory
  localparam int LIST_DEPTH = 16;
  localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
  localparam int MEM_DEPTH  = 2 * LIST_DEPTH;
  localparam int ADDR_W     = $clog2(MEM_DEPTH);

  // request kinds
  typedef enum logic [2:0] {
    KIND_CLEAR    = 3'd0,
    KIND_SET_USER = 3'd1,
    KIND_ADD      = 3'd2,
    KIND_GET      = 3'd3,
    KIND_MARK     = 3'd4
  } kind_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POP,
    ST_MARK,
    ST_SWAP,
    ST_EMIT
  } state_t;

  // request beat
  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  event_id;
    logic [7:0]  event_target;
    logic [31:0] event_data;
    logic        event_done;
  } req_t;

  // response beat
  typedef struct packed {
    logic [7:0]  out_id;
    logic [7:0]  out_target;
    logic [31:0] out_data;
    logic        out_done;
  } rsp_t;

  // stored event
  typedef struct packed {
    logic [7:0]  id;
    logic [7:0]  target;
    logic [31:0] data;
    logic        done;
  } entry_t;

  // memory address of entry idx of list sel
  function automatic logic [ADDR_W-1:0] list_addr(input logic sel,
                                                  input logic [CNT_W-1:0] idx);
    logic [ADDR_W:0] a;
    a = (ADDR_W + 1)'(idx) + (sel ? (ADDR_W + 1)'(LIST_DEPTH) : '0);
    return a[ADDR_W-1:0];
  endfunction

  // count after a push, saturating at the list depth
  function automatic logic [CNT_W-1:0] push_count(input logic [CNT_W-1:0] cnt);
    return (cnt == CNT_W'(LIST_DEPTH)) ? cnt : cnt + 1'b1;
  endfunction

  // entry still wants handling after a swap
  function automatic logic entry_live(input entry_t e);
    return (e.target != 8'd0) && !e.done;
  endfunction

endpackage

>>> rtl/double_buffered_event_stack_unit.sv
// double-buffered event stack: two lifo lists in one memory plus a user slot
// depends on dbes_pkg and double_buffered_event_stack_unit_macros.svh
`timescale 1ns / 1ps
`include "double_buffered_event_stack_unit_macros.svh"

//  channel | dir | handshake          | payload
//  req     | in  | req_valid/req_stall | dbes_pkg::req_t
//  rsp     | out | rsp_valid/rsp_stall | dbes_pkg::rsp_t
//
//  clear, set user slot and add are done in the idle state; a get served by the user slot needs no memory read
//  pop and mark: memory read in the idle state, then result (ST_POP) or write back (ST_MARK)
//  get on an empty list: swap walk over the swap_total entries of the old list through the one read port
//  synchronous reset clears control state; the list memory is not cleared
//  a get result waits in the rsp register (or a hold register) while rsp_stall is high

module double_buffered_event_stack_unit (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  dbes_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output dbes_pkg::rsp_t rsp
);

  // control and state registers
  dbes_pkg::state_t                   state, state_next;
  dbes_pkg::entry_t                   user_slot, user_slot_next;
  logic [dbes_pkg::CNT_W-1:0]         count_a, count_a_next;
  logic [dbes_pkg::CNT_W-1:0]         count_b, count_b_next;
  logic [dbes_pkg::CNT_W-1:0]         swap_total, swap_total_next;
  logic                               current_sel, current_sel_next;
  logic [dbes_pkg::CNT_W-1:0]         sw_rd, sw_rd_next;
  logic                               sw_pend, sw_pend_next;
  logic                               rsp_valid_next;
  dbes_pkg::rsp_t                     rsp_next;
  dbes_pkg::entry_t                   hold, hold_next;

  // memory and its ports
  dbes_pkg::entry_t                   mem [0:dbes_pkg::MEM_DEPTH-1];
  dbes_pkg::entry_t                   rdata;
  logic                               mem_we, mem_re;
  logic [dbes_pkg::ADDR_W-1:0]        mem_waddr, mem_raddr;
  dbes_pkg::entry_t                   mem_wdata;

  // shared conditions
  logic                               req_acc, user_hit, out_free, swap_last;
  logic [dbes_pkg::CNT_W-1:0]         cur_cnt, nxt_cnt, nxt_push;
  logic                               res_valid;
  dbes_pkg::entry_t                   res_val, req_entry;

  // terms for the checks
  logic                               counts_ok, in_swap, swap_done, user_get;

  assign req_stall = (state != dbes_pkg::ST_IDLE);
  assign req_acc   = req_valid && !req_stall;
  assign user_hit  = (user_slot.id != 8'd0);
  assign out_free  = !rsp_valid || !rsp_stall;
  assign swap_last = (sw_rd == swap_total);
  assign cur_cnt   = current_sel ? count_b : count_a;
  assign nxt_cnt   = current_sel ? count_a : count_b;
  assign nxt_push  = dbes_pkg::push_count(nxt_cnt);
  assign req_entry = '{id: req.event_id, target: req.event_target,
                       data: req.event_data, done: req.event_done};

  // next state
  always_comb begin
    state_next = state;
    case (state)
      dbes_pkg::ST_IDLE: begin
        if (req_acc && req.kind == dbes_pkg::KIND_GET) begin
          if (user_hit) begin
            state_next = out_free ? dbes_pkg::ST_IDLE : dbes_pkg::ST_EMIT;
          end else if (cur_cnt != '0) begin
            state_next = dbes_pkg::ST_POP;
          end else begin
            state_next = dbes_pkg::ST_SWAP;
          end
        end else if (req_acc && req.kind == dbes_pkg::KIND_MARK &&
                     cur_cnt != dbes_pkg::CNT_W'(dbes_pkg::LIST_DEPTH)) begin
          state_next = dbes_pkg::ST_MARK;
        end
      end
      dbes_pkg::ST_POP: begin
        state_next = out_free ? dbes_pkg::ST_IDLE : dbes_pkg::ST_EMIT;
      end
      dbes_pkg::ST_MARK: begin
        state_next = dbes_pkg::ST_IDLE;
      end
      dbes_pkg::ST_SWAP: begin
        if (swap_last) begin
          state_next = out_free ? dbes_pkg::ST_IDLE : dbes_pkg::ST_EMIT;
        end
      end
      dbes_pkg::ST_EMIT: begin
        state_next = out_free ? dbes_pkg::ST_IDLE : dbes_pkg::ST_EMIT;
      end
      default: begin
        state_next = dbes_pkg::ST_IDLE;
      end
    endcase
  end

  // datapath, memory accesses and results
  always_comb begin
    logic [dbes_pkg::CNT_W-1:0] nxt_after;
    user_slot_next   = user_slot;
    count_a_next     = count_a;
    count_b_next     = count_b;
    swap_total_next  = swap_total;
    current_sel_next = current_sel;
    sw_rd_next       = sw_rd;
    sw_pend_next     = sw_pend;
    mem_we           = 1'b0;
    mem_waddr        = '0;
    mem_wdata        = rdata;
    mem_re           = 1'b0;
    mem_raddr        = '0;
    res_valid        = 1'b0;
    res_val          = '0;
    nxt_after        = nxt_cnt;
    case (state)
      dbes_pkg::ST_IDLE: begin
        if (req_acc) begin
          case (req.kind)
            dbes_pkg::KIND_CLEAR: begin
              user_slot_next   = '0;
              count_a_next     = '0;
              count_b_next     = '0;
              swap_total_next  = '0;
              current_sel_next = 1'b0;
            end
            dbes_pkg::KIND_SET_USER: begin
              user_slot_next = req_entry;
            end
            dbes_pkg::KIND_ADD: begin
              // push onto the next list, top entry overwritten when full
              if (req.event_id != 8'd0) begin
                mem_we    = 1'b1;
                mem_waddr = dbes_pkg::list_addr(!current_sel, nxt_push - 1'b1);
                mem_wdata = req_entry;
                if (current_sel) count_a_next = nxt_push;
                else             count_b_next = nxt_push;
              end
            end
            dbes_pkg::KIND_GET: begin
              if (user_hit) begin
                res_valid      = 1'b1;
                res_val        = user_slot;
                user_slot_next = '0;
              end else if (cur_cnt != '0) begin
                // pop: read the top entry, data arrives next cycle
                mem_re    = 1'b1;
                mem_raddr = dbes_pkg::list_addr(current_sel, cur_cnt - 1'b1);
                if (current_sel) count_b_next = cur_cnt - 1'b1;
                else             count_a_next = cur_cnt - 1'b1;
              end else begin
                sw_rd_next   = '0;
                sw_pend_next = 1'b0;
              end
            end
            dbes_pkg::KIND_MARK: begin
              if (cur_cnt != dbes_pkg::CNT_W'(dbes_pkg::LIST_DEPTH)) begin
                mem_re    = 1'b1;
                mem_raddr = dbes_pkg::list_addr(current_sel, cur_cnt);
              end
            end
            default: begin
            end
          endcase
        end
      end
      dbes_pkg::ST_POP: begin
        res_valid = 1'b1;
        res_val   = rdata;
      end
      dbes_pkg::ST_MARK: begin
        // write back the entry with its done flag set
        mem_we         = 1'b1;
        mem_waddr      = dbes_pkg::list_addr(current_sel, cur_cnt);
        mem_wdata      = rdata;
        mem_wdata.done = 1'b1;
      end
      dbes_pkg::ST_SWAP: begin
        // re-push the entry read last cycle if still live
        if (sw_pend && dbes_pkg::entry_live(rdata)) begin
          mem_we    = 1'b1;
          mem_waddr = dbes_pkg::list_addr(!current_sel, nxt_push - 1'b1);
          mem_wdata = rdata;
          nxt_after = nxt_push;
          if (current_sel) count_a_next = nxt_push;
          else             count_b_next = nxt_push;
        end
        // read the following entry of the old current list
        if (!swap_last) begin
          mem_re       = 1'b1;
          mem_raddr    = dbes_pkg::list_addr(current_sel, sw_rd);
          sw_rd_next   = sw_rd + 1'b1;
          sw_pend_next = 1'b1;
        end else begin
          sw_pend_next     = 1'b0;
          if (current_sel) count_b_next = '0;
          else             count_a_next = '0;
          current_sel_next = !current_sel;
          swap_total_next  = nxt_after;
          res_valid        = 1'b1;
          res_val          = '0;
        end
      end
      dbes_pkg::ST_EMIT: begin
        res_valid = 1'b1;
        res_val   = hold;
      end
      default: begin
      end
    endcase
  end

  // response register with hold for a stalled output
  always_comb begin
    rsp_valid_next = rsp_valid;
    rsp_next       = rsp;
    hold_next      = hold;
    if (res_valid && out_free) begin
      rsp_valid_next = 1'b1;
      rsp_next       = '{out_id: res_val.id, out_target: res_val.target,
                         out_data: res_val.data, out_done: res_val.done};
    end else if (res_valid) begin
      hold_next = res_val;
    end else if (rsp_valid && !rsp_stall) begin
      rsp_valid_next = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= dbes_pkg::ST_IDLE;
      user_slot   <= '0;
      count_a     <= '0;
      count_b     <= '0;
      swap_total  <= '0;
      current_sel <= 1'b0;
      sw_rd       <= '0;
      sw_pend     <= 1'b0;
      rsp_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      user_slot   <= user_slot_next;
      count_a     <= count_a_next;
      count_b     <= count_b_next;
      swap_total  <= swap_total_next;
      current_sel <= current_sel_next;
      sw_rd       <= sw_rd_next;
      sw_pend     <= sw_pend_next;
      rsp_valid   <= rsp_valid_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    rsp  <= rsp_next;
    hold <= hold_next;
  end

  // list memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata <= mem[mem_raddr];
    end
  end

  // terms for the checks
  assign counts_ok = (count_a <= dbes_pkg::CNT_W'(dbes_pkg::LIST_DEPTH)) &&
                     (count_b <= dbes_pkg::CNT_W'(dbes_pkg::LIST_DEPTH));
  assign in_swap   = (state == dbes_pkg::ST_SWAP);
  assign swap_done = in_swap && swap_last;
  assign user_get  = req_acc && (req.kind == dbes_pkg::KIND_GET) && user_hit;

  // checks
  `DBES_ASSERT_ALWAYS(a_count_range, clk, rst, counts_ok, "list count above depth")
  `DBES_ASSERT_IMPL(a_swap_bound, clk, rst, in_swap, sw_rd <= swap_total, "swap walk past total")
  `DBES_ASSERT_NEXT(a_swap_flip, clk, rst, swap_done, $changed(current_sel), "no list exchange")
  `DBES_ASSERT_NEXT(a_user_taken, clk, rst, user_get, user_slot.id == 8'd0, "user slot kept")

endmodule

>>> tb/sv/tb_top.sv
// self-checking testbench for double_buffered_event_stack_unit
// predicts every get from its own copy of the two lists and the user slot
// depends on dbes_pkg and the unit rtl only
`timescale 1ns / 1ps

module tb_top;
  import dbes_pkg::*;

  localparam int RANDOM_ITEMS = 440;
  localparam int CALM_ITEMS   = 60;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 2 * LIST_DEPTH + 8;

  // request kinds the unit ignores
  localparam logic [2:0] KIND_SPARE_LO = 3'd5;
  localparam logic [2:0] KIND_SPARE_HI = 3'd7;

  // request mixes for the random part
  localparam int MIX_BALANCED = 0;
  localparam int MIX_FILL     = 1;
  localparam int MIX_DRAIN    = 2;

  // tracks list state and holds the events that gets must return
  class stack_checker;
    entry_t           user_slot;
    entry_t           store [MEM_DEPTH];
    bit               written [MEM_DEPTH];
    logic [CNT_W-1:0] fill [2];
    logic [CNT_W-1:0] swap_total;
    bit               cur;
    rsp_t             expected_events [$];
    int               errors;

    function new();
      foreach (written[i]) written[i] = 1'b0;
      errors = 0;
      clear_state();
    endfunction

    function void clear_state();
      user_slot  = '0;
      fill[0]    = '0;
      fill[1]    = '0;
      swap_total = '0;
      cur        = 1'b0;
    endfunction

    function int slot(bit sel, int idx);
      return (sel ? LIST_DEPTH : 0) + idx;
    endfunction

    function int pending();
      return expected_events.size();
    endfunction

    // a mark rewrites the entry above the current top, which must hold data
    function bit mark_allowed();
      int n;
      n = int'(fill[cur]);
      return (n >= LIST_DEPTH) || written[slot(cur, n)];
    endfunction

    // push onto the next list, overwriting the top when full
    function void push_next(entry_t e);
      bit nsel;
      int n;
      nsel = !cur;
      if (e.id == 8'd0) return;
      n = int'(fill[nsel]) + 1;
      if (n > LIST_DEPTH) n = LIST_DEPTH;
      fill[nsel] = CNT_W'(n);
      store[slot(nsel, n - 1)]   = e;
      written[slot(nsel, n - 1)] = 1'b1;
    endfunction

    // carry live entries over, then exchange roles
    function void swap_lists();
      int     lim;
      int     i;
      entry_t e;
      lim = int'(swap_total);
      if (lim > LIST_DEPTH) lim = LIST_DEPTH;
      for (i = 0; i < lim; i++) begin
        e = store[slot(cur, i)];
        if (e.target != 8'd0 && !e.done) push_next(e);
      end
      fill[cur]  = '0;
      cur        = !cur;
      swap_total = fill[cur];
    endfunction

    // update state for one accepted request beat
    function void note_request(req_t r);
      entry_t e;
      entry_t got;
      rsp_t   x;
      e.id     = r.event_id;
      e.target = r.event_target;
      e.data   = r.event_data;
      e.done   = r.event_done;
      case (r.kind)
        KIND_CLEAR:    clear_state();
        KIND_SET_USER: user_slot = e;
        KIND_ADD:      push_next(e);
        KIND_GET: begin
          got = '0;
          if (user_slot.id != 8'd0) begin
            got       = user_slot;
            user_slot = '0;
          end else if (fill[cur] != '0) begin
            got       = store[slot(cur, int'(fill[cur]) - 1)];
            fill[cur] = fill[cur] - 1'b1;
          end else begin
            swap_lists();
          end
          x.out_id     = got.id;
          x.out_target = got.target;
          x.out_data   = got.data;
          x.out_done   = got.done;
          expected_events.push_back(x);
        end
        KIND_MARK: begin
          if (int'(fill[cur]) < LIST_DEPTH) store[slot(cur, int'(fill[cur]))].done = 1'b1;
        end
        default: ;
      endcase
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 100) $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    // compare one response beat with the oldest expected event
    task check_event(rsp_t got);
      rsp_t want;
      if (expected_events.size() == 0) begin
        report($sformatf("event with no get pending, id %0h", got.out_id));
        return;
      end
      want = expected_events.pop_front();
      if (got.out_id !== want.out_id)
        report($sformatf("out_id %0h, wanted %0h", got.out_id, want.out_id));
      if (got.out_target !== want.out_target)
        report($sformatf("out_target %0h, wanted %0h", got.out_target, want.out_target));
      if (got.out_data !== want.out_data)
        report($sformatf("out_data %0h, wanted %0h", got.out_data, want.out_data));
      if (got.out_done !== want.out_done)
        report($sformatf("out_done %0b, wanted %0b", got.out_done, want.out_done));
    endtask
  endclass

  logic clk;
  logic rst;
  logic req_valid;
  logic req_stall;
  req_t req;
  logic rsp_valid;
  logic rsp_stall;
  rsp_t rsp;

  stack_checker chk = new;

  bit calm;
  int sender_idle_pct;
  int stall_left;
  int free_left;
  int quiet_cycles;

  double_buffered_event_stack_unit dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // sample both channels and watch for a hung unit
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles = 0;
    end else begin
      if (req_valid && !req_stall) chk.note_request(req);
      if (rsp_valid && !rsp_stall) chk.check_event(rsp);
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("TB_ERROR");
          $finish;
        end
      end
    end
  end

  // response stall in bursts, with long open stretches
  always @(negedge clk) begin
    if (rst || calm) begin
      stall_left = 0;
      free_left  = 0;
      rsp_stall <= 1'b0;
    end else begin
      if (stall_left == 0 && free_left == 0) begin
        if ($urandom_range(0, 4) == 0) begin
          free_left = $urandom_range(20, 60);
        end else begin
          stall_left = $urandom_range(1, 5);
          free_left  = $urandom_range(0, 6);
        end
      end
      if (stall_left > 0) begin
        rsp_stall <= 1'b1;
        stall_left--;
      end else begin
        rsp_stall <= 1'b0;
        free_left--;
      end
    end
  end

  // present one request beat; called and returns at a falling edge
  task automatic send_request(req_t r);
    if (!calm && $urandom_range(0, 99) < sender_idle_pct) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    req       <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    @(negedge clk);
  endtask

  task automatic send_fields(logic [2:0] k, logic [7:0] id, logic [7:0] tgt,
                             logic [31:0] data, logic done);
    req_t r;
    r.kind         = k;
    r.event_id     = id;
    r.event_target = tgt;
    r.event_data   = data;
    r.event_done   = done;
    send_request(r);
  endtask

  // sender holds off until every get has been answered
  task automatic hold_until_drained();
    req_valid <= 1'b0;
    @(negedge clk);
    while (chk.pending() != 0) @(negedge clk);
  endtask

  // random request under the given mix; marks mostly follow a get
  task automatic make_request(input int mix, input bit after_get, output req_t r);
    int roll;
    int w_clear;
    int w_set;
    int w_add;
    int w_get;
    int w_mark;
    r.event_id     = ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
    r.event_target = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
    r.event_data   = $urandom;
    r.event_done   = ($urandom_range(0, 3) == 0);
    case (mix)
      MIX_FILL: begin
        w_clear = 1; w_set = 4; w_add = 75; w_get = 12; w_mark = 6;
      end
      MIX_DRAIN: begin
        w_clear = 1; w_set = 6; w_add = 20; w_get = 60; w_mark = 11;
      end
      default: begin
        w_clear = 2; w_set = 8; w_add = 40; w_get = 38; w_mark = 10;
      end
    endcase
    roll = $urandom_range(0, 99);
    if (after_get && $urandom_range(0, 2) == 0)
      r.kind = KIND_MARK;
    else if (roll < w_clear)
      r.kind = KIND_CLEAR;
    else if (roll < w_clear + w_set)
      r.kind = KIND_SET_USER;
    else if (roll < w_clear + w_set + w_add)
      r.kind = KIND_ADD;
    else if (roll < w_clear + w_set + w_add + w_get)
      r.kind = KIND_GET;
    else if (roll < w_clear + w_set + w_add + w_get + w_mark)
      r.kind = KIND_MARK;
    else
      r.kind = 3'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
    if (r.kind == KIND_MARK && !chk.mark_allowed()) r.kind = KIND_GET;
  endtask

  initial begin
    req_t r;
    int   effective;
    int   block_left;
    int   mix;
    bit   after_get;
    int   i;

    rst             = 1'b1;
    req_valid       = 1'b0;
    req             = '0;
    rsp_stall       = 1'b0;
    calm            = 1'b0;
    sender_idle_pct = 25;
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: extremes, full list with overwrite, user slot, marks
    send_fields(KIND_CLEAR, 8'd0, 8'd0, 32'd0, 1'b0);
    send_fields(KIND_ADD, 8'd0, 8'hff, 32'hffff_ffff, 1'b1);
    send_fields(KIND_ADD, 8'hff, 8'hff, 32'hffff_ffff, 1'b1);
    send_fields(KIND_ADD, 8'h01, 8'h00, 32'h0000_0000, 1'b0);
    send_fields(KIND_ADD, 8'h80, 8'h01, 32'h8000_0000, 1'b0);
    for (i = 0; i < 14; i++)
      send_fields(KIND_ADD, 8'($urandom_range(1, 255)), 8'($urandom), $urandom,
                  1'($urandom));
    send_fields(KIND_SET_USER, 8'd0, 8'd0, 32'd0, 1'b0);
    // empty current list gives a null event and swaps
    send_fields(KIND_GET, 8'd0, 8'd0, 32'd0, 1'b0);
    // current list is full, so this mark is dropped
    send_fields(KIND_MARK, 8'd0, 8'd0, 32'd0, 1'b0);
    send_fields(KIND_SET_USER, 8'haa, 8'h55, 32'h5555_aaaa, 1'b1);
    send_fields(KIND_GET, 8'd0, 8'd0, 32'd0, 1'b0);
    send_fields(KIND_GET, 8'd0, 8'd0, 32'd0, 1'b0);
    send_fields(KIND_MARK, 8'hff, 8'hff, 32'hffff_ffff, 1'b1);
    send_fields(KIND_SPARE_HI, 8'($urandom), 8'($urandom), $urandom, 1'($urandom));
    send_fields(KIND_GET, 8'd0, 8'd0, 32'd0, 1'b0);

    // random part in blocks of one mix each
    effective  = 0;
    block_left = 0;
    mix        = MIX_BALANCED;
    after_get  = 1'b0;
    while (effective < RANDOM_ITEMS) begin
      if (block_left == 0) begin
        mix             = $urandom_range(MIX_BALANCED, MIX_DRAIN);
        sender_idle_pct = ($urandom_range(0, 3) == 0) ? 0 : 30;
        block_left      = 20;
      end
      block_left--;
      if (effective >= RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
      if (effective == 150 || $urandom_range(0, 149) == 0) hold_until_drained();
      make_request(mix, after_get, r);
      send_request(r);
      after_get = (r.kind == KIND_GET);
      if (!(r.kind >= KIND_SPARE_LO || (r.kind == KIND_ADD && r.event_id == 8'd0)))
        effective++;
    end
    req_valid <= 1'b0;

    // let the last events come out, then allow for a trailing swap
    while (chk.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (chk.errors == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
